FILE: hdl/first_fit_chunk_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit chunk allocator
// Shorthand for clocked implication checks that the allocator modules use.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FFCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FFCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Constants, codes and controller/datapath interface types of the allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  // Pool geometry.
  localparam int POOL_WORDS = 1024;
  localparam int MIN_POOL   = 3;
  localparam int RESET_POOL = 1024;
  localparam int RESET_LEN  = (RESET_POOL > POOL_WORDS) ? POOL_WORDS : RESET_POOL;
  localparam int ADDR_W     = $clog2(POOL_WORDS);
  localparam int PLEN_W     = ADDR_W + 1;

  // Field widths.
  localparam int CFG_W   = 11;
  localparam int REQ_W   = 14;
  localparam int OFF_W   = 13;
  localparam int LARGE_W = 14;
  localparam int NEED_W  = REQ_W - 2;
  localparam int HDR_W   = 12;
  localparam int POS_W   = 12;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // Kind of result to load into the output register.
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_TAKEN,
    RES_FAIL,
    RES_LARGEST
  } res_kind_t;

  // Datapath actions.
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_LATCH,
    ACT_INIT_WR,
    ACT_FREE_RD,
    ACT_FREE_WR,
    ACT_POS_START,
    ACT_POS_RD,
    ACT_TAKE_STEP,
    ACT_TAKE_EXACT,
    ACT_SPLIT_HEAD,
    ACT_SPLIT_REST,
    ACT_MG_START,
    ACT_FIRST_RD,
    ACT_SKIP_STEP,
    ACT_RUN_START,
    ACT_LAST_RD,
    ACT_RUN_STEP,
    ACT_MG_WR,
    ACT_Q_STEP,
    ACT_LOAD_RES
  } act_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_FREE_WR,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_SPLIT,
    ST_MG_FIRST_RD,
    ST_MG_FIRST_CHK,
    ST_MG_LAST_RD,
    ST_MG_LAST_CHK,
    ST_MG_WR,
    ST_Q_RD,
    ST_Q_CHK,
    ST_DONE
  } state_t;

  // Command from controller to datapath.
  typedef struct packed {
    act_t      act;
    res_kind_t kind;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    op_t  op;
    logic free_ok;
    logic pos_end;
    logic first_end;
    logic last_end;
    logic hdr_neg;
    logic hdr_lt_need;
    logic hdr_eq_need;
    logic clr_last;
  } dp_status_t;

endpackage

FILE: hdl/ffca_dpath.sv
// ----------------------------------------------------------------------------
// ffca_dpath
// Header memory, walk pointers, comparisons and the output register.
// ----------------------------------------------------------------------------
module ffca_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [ffca_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [1:0]                     op,
  input  logic [ffca_pkg::REQ_W-1:0]     request_bytes,
  input  logic [ffca_pkg::OFF_W-1:0]     chunk_offset,
  input  ffca_pkg::dp_cmd_t              cmd,
  output ffca_pkg::dp_status_t           status,
  output logic                           ok,
  output logic [ffca_pkg::OFF_W-1:0]     payload_offset,
  output logic [ffca_pkg::LARGE_W-1:0]   largest_bytes
);
  import ffca_pkg::*;

  // Header store: one signed word count per pool word.
  logic signed [HDR_W-1:0] mem [POOL_WORDS];

  logic [CFG_W-1:0]        pool_words;
  logic [ADDR_W-1:0]       clr_cnt;
  op_t                     op_q;
  logic [NEED_W-1:0]       need;
  logic [ADDR_W-1:0]       free_hdr;
  logic                    free_ok;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        first;
  logic [POS_W-1:0]        last;
  logic signed [HDR_W-1:0] best;
  logic signed [HDR_W-1:0] rdata;

  logic [PLEN_W-1:0]       plen;
  logic [POS_W-1:0]        plen_pos;
  logic [HDR_W-1:0]        mag;
  logic [POS_W-1:0]        pos_step;
  logic [POS_W-1:0]        first_step;
  logic [POS_W-1:0]        last_step;
  logic [POS_W-1:0]        last_clip;
  logic [POS_W-1:0]        pos_inc;
  logic [POS_W-1:0]        split_pos;
  logic [REQ_W:0]          req_sum;
  logic [ADDR_W-1:0]       off_word;
  logic [ADDR_W-1:0]       off_hdr;
  logic signed [HDR_W:0]   hdr_x;
  logic signed [HDR_W:0]   need_x;

  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [HDR_W-1:0] wr_data;

  // Pool length clamped to the supported range.
  always_comb begin
    if (pool_words < CFG_W'(MIN_POOL)) begin
      plen = PLEN_W'(MIN_POOL);
    end else if (pool_words > CFG_W'(POOL_WORDS)) begin
      plen = PLEN_W'(POOL_WORDS);
    end else begin
      plen = PLEN_W'(pool_words);
    end
  end

  // Step arithmetic and comparisons on the header just read.
  assign plen_pos   = POS_W'(plen);
  assign mag        = rdata[HDR_W-1] ? HDR_W'(-rdata) : HDR_W'(rdata);
  assign pos_step   = pos + POS_W'(1) + POS_W'(mag);
  assign first_step = first + POS_W'(1) + POS_W'(mag);
  assign last_step  = last + POS_W'(1) + POS_W'(mag);
  assign last_clip  = (last > plen_pos) ? plen_pos : last;
  assign pos_inc    = pos + POS_W'(1);
  assign split_pos  = pos + POS_W'(1) + POS_W'(need);
  assign hdr_x      = {rdata[HDR_W-1], rdata};
  assign need_x     = {1'b0, need};

  // Request rounding and free offset decode.
  assign req_sum  = {1'b0, request_bytes} + (REQ_W+1)'(7);
  assign off_word = chunk_offset[OFF_W-1:3];
  assign off_hdr  = off_word - ADDR_W'(1);

  // Status back to the controller.
  always_comb begin
    status.op          = op_q;
    status.free_ok     = free_ok;
    status.pos_end     = (pos >= plen_pos);
    status.first_end   = (first >= plen_pos);
    status.last_end    = (last >= plen_pos);
    status.hdr_neg     = rdata[HDR_W-1];
    status.hdr_lt_need = (hdr_x < need_x);
    status.hdr_eq_need = (hdr_x == need_x);
    status.clr_last    = (clr_cnt == ADDR_W'(POOL_WORDS - 1));
  end

  // Memory port decode from the current action.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = pos[ADDR_W-1:0];
    wr_data = -rdata;
    unique case (cmd.act)
      ACT_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = (clr_cnt == ADDR_W'(1)) ? HDR_W'(RESET_LEN - 2) : '0;
      end
      ACT_INIT_WR: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(1);
        wr_data = HDR_W'(plen - PLEN_W'(2));
      end
      ACT_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = free_hdr;
      end
      ACT_FREE_WR: begin
        wr_en   = 1'b1;
        wr_addr = free_hdr;
      end
      ACT_POS_RD: begin
        rd_en = 1'b1;
      end
      ACT_TAKE_EXACT: begin
        wr_en = 1'b1;
      end
      ACT_SPLIT_HEAD: begin
        wr_en   = 1'b1;
        wr_data = HDR_W'(0) - HDR_W'(need);
      end
      ACT_SPLIT_REST: begin
        wr_en   = 1'b1;
        wr_addr = split_pos[ADDR_W-1:0];
        wr_data = rdata - HDR_W'(need) - HDR_W'(1);
      end
      ACT_FIRST_RD: begin
        rd_en   = 1'b1;
        rd_addr = first[ADDR_W-1:0];
      end
      ACT_LAST_RD: begin
        rd_en   = 1'b1;
        rd_addr = last[ADDR_W-1:0];
      end
      ACT_MG_WR: begin
        wr_en   = 1'b1;
        wr_addr = first[ADDR_W-1:0];
        wr_data = HDR_W'(last_clip - first - POS_W'(1));
      end
      default: begin
      end
    endcase
  end

  // Header store ports: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Configuration register and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_words <= CFG_W'(RESET_POOL);
      clr_cnt    <= '0;
    end else begin
      if (cfg_wen) begin
        pool_words <= cfg_wdata;
      end
      if (cmd.act == ACT_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  // Walk registers and item fields.
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      ACT_LATCH: begin
        op_q     <= op_t'(op);
        need     <= req_sum[REQ_W:3];
        free_hdr <= off_hdr;
        free_ok  <= (off_word != '0) && ({1'b0, off_hdr} < plen);
      end
      ACT_POS_START: begin
        pos  <= POS_W'(1);
        best <= '0;
      end
      ACT_TAKE_STEP: begin
        pos <= pos_step;
      end
      ACT_Q_STEP: begin
        pos <= pos_step;
        if (rdata > best) begin
          best <= rdata;
        end
      end
      ACT_MG_START: begin
        first <= POS_W'(1);
      end
      ACT_SKIP_STEP: begin
        first <= first_step;
      end
      ACT_RUN_START: begin
        last <= first_step;
      end
      ACT_RUN_STEP: begin
        last <= last_step;
      end
      ACT_MG_WR: begin
        first <= last_clip;
      end
      ACT_LOAD_RES: begin
        ok             <= (cmd.kind != RES_FAIL);
        payload_offset <= (cmd.kind == RES_TAKEN) ? {pos_inc[OFF_W-4:0], 3'b000} : '0;
        largest_bytes  <= (cmd.kind == RES_LARGEST) ? {best[LARGE_W-4:0], 3'b000} : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/ffca_ctrl.sv
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer for init, allocate, free and query; owns the beat handshakes.
// ----------------------------------------------------------------------------
module ffca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  ffca_pkg::dp_status_t  status,
  output ffca_pkg::dp_cmd_t     cmd
);
  import ffca_pkg::*;

  state_t    state, state_next;
  res_kind_t kind, kind_next;
  logic      retry, retry_next;
  logic      out_valid_next;
  logic      slot_free;

  // The output slot can take a new beat when empty or being drained.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      kind      <= RES_PLAIN;
      retry     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      kind      <= kind_next;
      retry     <= retry_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    kind_next      = kind;
    retry_next     = retry;
    out_valid_next = out_valid && out_stall;
    cmd.act        = ACT_NONE;
    cmd.kind       = kind;
    unique case (state)
      ST_CLEAR: begin
        cmd.act = ACT_CLEAR;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.act    = ACT_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status.op)
          OP_INIT: begin
            cmd.act    = ACT_INIT_WR;
            kind_next  = RES_PLAIN;
            state_next = ST_DONE;
          end
          OP_ALLOC: begin
            cmd.act    = ACT_POS_START;
            retry_next = 1'b0;
            state_next = ST_TK_RD;
          end
          OP_FREE: begin
            kind_next = RES_PLAIN;
            if (status.free_ok) begin
              cmd.act    = ACT_FREE_RD;
              state_next = ST_FREE_WR;
            end else begin
              state_next = ST_DONE;
            end
          end
          default: begin
            cmd.act    = ACT_MG_START;
            state_next = ST_MG_FIRST_RD;
          end
        endcase
      end
      ST_FREE_WR: begin
        cmd.act    = ACT_FREE_WR;
        state_next = ST_DONE;
      end
      // First-fit walk over the chunk headers.
      ST_TK_RD: begin
        if (status.pos_end) begin
          if (retry) begin
            kind_next  = RES_FAIL;
            state_next = ST_DONE;
          end else begin
            cmd.act    = ACT_MG_START;
            state_next = ST_MG_FIRST_RD;
          end
        end else begin
          cmd.act    = ACT_POS_RD;
          state_next = ST_TK_CHK;
        end
      end
      ST_TK_CHK: begin
        if (status.hdr_lt_need) begin
          cmd.act    = ACT_TAKE_STEP;
          state_next = ST_TK_RD;
        end else if (status.hdr_eq_need) begin
          cmd.act    = ACT_TAKE_EXACT;
          kind_next  = RES_TAKEN;
          state_next = ST_DONE;
        end else begin
          cmd.act    = ACT_SPLIT_HEAD;
          state_next = ST_TK_SPLIT;
        end
      end
      ST_TK_SPLIT: begin
        cmd.act    = ACT_SPLIT_REST;
        kind_next  = RES_TAKEN;
        state_next = ST_DONE;
      end
      // Merge pass: skip used chunks, then coalesce a run of free ones.
      ST_MG_FIRST_RD: begin
        if (status.first_end) begin
          cmd.act = ACT_POS_START;
          if (status.op == OP_ALLOC) begin
            retry_next = 1'b1;
            state_next = ST_TK_RD;
          end else begin
            state_next = ST_Q_RD;
          end
        end else begin
          cmd.act    = ACT_FIRST_RD;
          state_next = ST_MG_FIRST_CHK;
        end
      end
      ST_MG_FIRST_CHK: begin
        if (status.hdr_neg) begin
          cmd.act    = ACT_SKIP_STEP;
          state_next = ST_MG_FIRST_RD;
        end else begin
          cmd.act    = ACT_RUN_START;
          state_next = ST_MG_LAST_RD;
        end
      end
      ST_MG_LAST_RD: begin
        if (status.last_end) begin
          state_next = ST_MG_WR;
        end else begin
          cmd.act    = ACT_LAST_RD;
          state_next = ST_MG_LAST_CHK;
        end
      end
      ST_MG_LAST_CHK: begin
        if (status.hdr_neg) begin
          state_next = ST_MG_WR;
        end else begin
          cmd.act    = ACT_RUN_STEP;
          state_next = ST_MG_LAST_RD;
        end
      end
      ST_MG_WR: begin
        cmd.act    = ACT_MG_WR;
        state_next = ST_MG_FIRST_RD;
      end
      // Largest-free scan after the merge.
      ST_Q_RD: begin
        if (status.pos_end) begin
          kind_next  = RES_LARGEST;
          state_next = ST_DONE;
        end else begin
          cmd.act    = ACT_POS_RD;
          state_next = ST_Q_CHK;
        end
      end
      ST_Q_CHK: begin
        cmd.act    = ACT_Q_STEP;
        state_next = ST_Q_RD;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.act        = ACT_LOAD_RES;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `include "first_fit_chunk_allocator_top_assert.svh"

  `FFCA_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state == ST_DISPATCH, "accepted beat did not reach dispatch")
  `FFCA_ASSERT_NEXT(a_done_holds, state == ST_DONE && out_valid && out_stall, state == ST_DONE && out_valid, "result left while output slot was blocked")
  `FFCA_ASSERT_NEXT(a_done_loads, state == ST_DONE && slot_free, out_valid && state == ST_IDLE, "finished result was not presented")
  `FFCA_ASSERT_NEXT(a_retry_fails, state == ST_TK_RD && status.pos_end && retry, state == ST_DONE && kind == RES_FAIL, "second failed walk did not report failure")

endmodule

FILE: hdl/first_fit_chunk_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator_top
// First-fit variable-size allocator over a pool of eight-byte words.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Beat contents
//   -------  ---------  -------------------  ---------------------------------------
//   config   in         cfg_wen              cfg_wdata (pool_words)
//   input    in         in_valid / in_stall  op, request_bytes, chunk_offset
//   output   out        out_valid/out_stall  ok, payload_offset, largest_bytes
//
// One item at a time: a new item is accepted only after the last result is loaded.
// Allocate and query read each header (registered read, then compare); a merge pass
// rereads the used header that ends each free run; a failed allocate walks, merges
// and walks again, and a query merges and then scans for the largest free chunk.
// After reset a clearing pass writes all 1024 header words, one per cycle; no item is accepted.
// A stalled output holds one finished result while the next item is accepted and worked on.
//
module first_fit_chunk_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [ffca_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [ffca_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ffca_pkg::OFF_W-1:0]    chunk_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic [ffca_pkg::OFF_W-1:0]    payload_offset,
  output logic [ffca_pkg::LARGE_W-1:0]  largest_bytes
);
  import ffca_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  ffca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Header memory and walk datapath.
  ffca_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .op             (op),
    .request_bytes  (request_bytes),
    .chunk_offset   (chunk_offset),
    .cmd            (cmd),
    .status         (status),
    .ok             (ok),
    .payload_offset (payload_offset),
    .largest_bytes  (largest_bytes)
  );

endmodule

FILE: tb/sv/first_fit_chunk_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit chunk allocator result checker
// Watches the configuration, input and output channels of the allocator. It
// keeps its own copy of the pool's chunk headers and the pool size, works out
// the reply to every accepted input beat, and compares each output beat, field
// by field, with the oldest reply still owed.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [ffca_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [ffca_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ffca_pkg::OFF_W-1:0]    chunk_offset,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          ok,
  input  logic [ffca_pkg::OFF_W-1:0]    payload_offset,
  input  logic [ffca_pkg::LARGE_W-1:0]  largest_bytes,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_seen
);
  import ffca_pkg::*;

  typedef struct packed {
    logic               granted;
    logic [OFF_W-1:0]   offset;
    logic [LARGE_W-1:0] largest;
  } pool_reply_t;

  // Signed size of every pool word, in words; only chunk headers matter.
  int               hdr_words [POOL_WORDS];
  logic [CFG_W-1:0] pool_setting;
  pool_reply_t      owed_replies [$];

  // Pool length in words as the block uses it: the register clamped to range.
  function automatic int active_words();
    int p;
    p = int'(pool_setting);
    if (p < MIN_POOL) p = MIN_POOL;
    if (p > POOL_WORDS) p = POOL_WORDS;
    return p;
  endfunction

  // Distance from a header to the next one.
  function automatic int step_from(int size);
    return (size < 0) ? 1 - size : 1 + size;
  endfunction

  // Join every run of neighboring free chunks into one; a run is cut at the end.
  function automatic void coalesce_free();
    int p;
    int first;
    int last;
    p = active_words();
    first = 1;
    while (first < p) begin
      while (first < p && hdr_words[first] < 0) first += step_from(hdr_words[first]);
      if (first >= p) break;
      last = first;
      while (last < p && hdr_words[last] >= 0) last += 1 + hdr_words[last];
      if (last > p) last = p;
      hdr_words[first] = last - first - 1;
      first = last;
    end
  endfunction

  // First-fit search; returns the header word of the chunk taken, or 0.
  function automatic int take_first_fit(int need);
    int p;
    int pos;
    int have;
    p = active_words();
    pos = 1;
    while (pos < p && hdr_words[pos] < need) pos += step_from(hdr_words[pos]);
    if (pos >= p) return 0;
    have = hdr_words[pos];
    hdr_words[pos] = -need;
    // A chunk larger than needed always has room for the remainder header.
    if (have != need) hdr_words[pos + 1 + need] = have - need - 1;
    return pos;
  endfunction

  // Apply one input beat to the pool copy and return the reply it earns.
  function automatic pool_reply_t apply_beat(op_t code, logic [REQ_W-1:0] req,
                                            logic [OFF_W-1:0] off);
    pool_reply_t reply;
    int          need;
    int          pos;
    int          p;
    int          best;
    int          word;
    int          bytes;
    reply = '0;
    reply.granted = 1'b1;
    case (code)
      OP_INIT: begin
        hdr_words[1] = active_words() - 2;
      end
      OP_ALLOC: begin
        need = (int'(req) + 7) >> 3;
        pos = take_first_fit(need);
        if (pos == 0) begin
          coalesce_free();
          pos = take_first_fit(need);
        end
        if (pos == 0) begin
          reply.granted = 1'b0;
        end else begin
          bytes = (pos + 1) << 3;
          reply.offset = bytes[OFF_W-1:0];
        end
      end
      OP_FREE: begin
        // Low three bits are dropped; the header sits one word before the payload.
        word = int'(off) >> 3;
        if (word >= 1 && word - 1 < active_words()) hdr_words[word - 1] = -hdr_words[word - 1];
      end
      default: begin
        coalesce_free();
        p = active_words();
        pos = 1;
        best = 0;
        while (pos < p) begin
          if (hdr_words[pos] > best) best = hdr_words[pos];
          pos += step_from(hdr_words[pos]);
        end
        bytes = best << 3;
        reply.largest = bytes[LARGE_W-1:0];
      end
    endcase
    return reply;
  endfunction

  // Channel monitor: results are retired before a new beat is predicted.
  always @(posedge clk) begin : monitor
    pool_reply_t seen;
    pool_reply_t want;
    if (rst) begin
      for (int i = 0; i < POOL_WORDS; i++) hdr_words[i] = 0;
      hdr_words[1] = RESET_LEN - 2;
      pool_setting = RESET_POOL[CFG_W-1:0];
      owed_replies.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        seen = '{granted: ok, offset: payload_offset, largest: largest_bytes};
        if (owed_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result beat %0d with no item outstanding: ok=%0d offset=%0d largest=%0d",
                     results_seen, seen.granted, seen.offset, seen.largest);
        end else begin
          want = owed_replies.pop_front();
          if (seen.granted !== want.granted || seen.offset !== want.offset ||
              seen.largest !== want.largest) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result beat %0d: expected ok=%0d offset=%0d largest=%0d, %s%0d %0d %0d",
                       results_seen, want.granted, want.offset, want.largest,
                       "got ok/offset/largest=", seen.granted, seen.offset, seen.largest);
          end
        end
      end
      if (cfg_wen) pool_setting = cfg_wdata;
      if (in_valid && !in_stall)
        owed_replies.push_back(apply_beat(op_t'(op), request_bytes, chunk_offset));
    end
    outstanding = owed_replies.size();
  end

endmodule

FILE: tb/sv/tb_first_fit_chunk_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit chunk allocator testbench
// Drives init, allocate, free and query beats into the allocator across a
// range of pool sizes, with random gaps on the input and random stalls on the
// output. A checker beside the block predicts every reply and counts
// mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_first_fit_chunk_allocator_top;
  import ffca_pkg::*;

  // Cycles with no beat moving before the run is declared hung.
  localparam int HANG_LIMIT = 40000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = OP_INIT;
  logic [REQ_W-1:0]   request_bytes = '0;
  logic [OFF_W-1:0]   chunk_offset = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic [OFF_W-1:0]   payload_offset;
  logic [LARGE_W-1:0] largest_bytes;

  int mismatches;
  int outstanding;
  int results_seen;

  // Stimulus bookkeeping.
  bit   quiet_in = 1'b0;
  bit   quiet_out = 1'b0;
  int   cur_words = RESET_LEN;
  int   settings_run = 1;
  int   op_count [4];
  int   failed_allocs = 0;
  int   quiet_cycles = 0;
  int   live_offsets [$];
  op_t  issued_ops [$];
  op_t  done_op;

  always #10 clk = ~clk;

  first_fit_chunk_allocator_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .request_bytes  (request_bytes),
    .chunk_offset   (chunk_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .payload_offset (payload_offset),
    .largest_bytes  (largest_bytes)
  );

  first_fit_chunk_allocator_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .request_bytes  (request_bytes),
    .chunk_offset   (chunk_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .payload_offset (payload_offset),
    .largest_bytes  (largest_bytes),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen)
  );

  // Track granted payload offsets so that most frees name a real chunk.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall && issued_ops.size() > 0) begin
        done_op = issued_ops.pop_front();
        if (done_op == OP_ALLOC) begin
          if (ok) live_offsets.push_back(int'(payload_offset));
          else failed_allocs++;
        end
      end
      if (in_valid && !in_stall) begin
        issued_ops.push_back(op_t'(op));
        op_count[op]++;
      end
    end
  end

  // Result sink: stall a random number of cycles before taking each beat.
  initial begin : result_sink
    int hold;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = quiet_out ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Hang detection: no beat on any channel for too long ends the run.
  initial begin : hang_watch
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_wen || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("No beat moved for %0d cycles.", HANG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Present one beat after a random gap and hold it until it is taken.
  task automatic send_item(op_t code, int req, int off);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    request_bytes <= req[REQ_W-1:0];
    chunk_offset <= off[OFF_W-1:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending and wait for every owed reply.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly small requests, some near the pool size, a few anywhere in the field.
  function automatic int pick_request();
    int cap;
    int roll;
    cap = (cur_words - 2) * 8;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, (cap / 6 > 8) ? cap / 6 : 8);
    if (roll < 90) return $urandom_range(0, cap + 8);
    return $urandom_range(0, 16383);
  endfunction

  // Mostly a granted offset, sometimes with junk in the low bits; else noise.
  function automatic int pick_free_offset();
    int idx;
    int v;
    int junk;
    if (live_offsets.size() > 0 && $urandom_range(0, 9) < 8) begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      v = live_offsets[idx];
      live_offsets.delete(idx);
      junk = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) v[2:0] = junk[2:0];
      return v;
    end
    return $urandom_range(0, 8191);
  endfunction

  // Move to a new pool size while idle, optionally laying out a fresh pool.
  task automatic start_phase(int setting, bit fresh);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_wdata <= setting[CFG_W-1:0];
    @(negedge clk);
    cfg_wen <= 1'b0;
    cur_words = (setting < MIN_POOL) ? MIN_POOL : ((setting > POOL_WORDS) ? POOL_WORDS : setting);
    settings_run++;
    quiet_in = ($urandom_range(0, 3) == 0);
    quiet_out = ($urandom_range(0, 3) == 0);
    if (fresh) begin
      live_offsets.delete();
      send_item(OP_INIT, $urandom_range(0, 16383), $urandom_range(0, 8191));
    end
  endtask

  // Random mix weighted toward allocate and free; unused fields carry noise.
  task automatic random_items(int n);
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        send_item(OP_ALLOC, pick_request(), $urandom_range(0, 8191));
      end else if (roll < 80) begin
        send_item(OP_FREE, $urandom_range(0, 16383), pick_free_offset());
      end else if (roll < 95) begin
        send_item(OP_QUERY, $urandom_range(0, 16383), $urandom_range(0, 8191));
      end else begin
        live_offsets.delete();
        send_item(OP_INIT, $urandom_range(0, 16383), $urandom_range(0, 8191));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sequence on the reset layout: one free chunk of 1022 words.
    send_item(OP_QUERY, 16383, 8191);
    send_item(OP_ALLOC, 0, 0);          // zero bytes splits off an empty chunk
    send_item(OP_ALLOC, 0, 0);          // the empty chunk is an exact fit
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, 8, 0);
    send_item(OP_ALLOC, 9, 0);
    send_item(OP_ALLOC, 16383, 0);      // largest field value, no room
    send_item(OP_ALLOC, 8192, 8191);    // no room even after merging
    send_item(OP_ALLOC, 8112, 0);       // exact fit of the rest of the pool
    send_item(OP_FREE, 0, 24);
    send_item(OP_FREE, 0, 43);          // low bits of the offset are dropped
    send_item(OP_ALLOC, 24, 0);         // fits only after neighbors are merged
    send_item(OP_FREE, 16383, 0);       // offsets below one word are ignored
    send_item(OP_FREE, 0, 7);
    send_item(OP_FREE, 0, 8191);        // trusted although it names no chunk
    send_item(OP_FREE, 0, 80);
    send_item(OP_FREE, 0, 80);          // freeing twice marks the chunk used again
    send_item(OP_QUERY, 0, 0);
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_INIT, 0, 0);
    send_item(OP_QUERY, 0, 0);
    send_item(OP_ALLOC, 8176, 0);       // whole pool in one chunk
    send_item(OP_ALLOC, 0, 0);          // zero bytes with nothing free
    send_item(OP_FREE, 0, 16);
    send_item(OP_INIT, 0, 0);

    // Smallest pools, including a setting below range that clamps up.
    start_phase(3, 1'b1);
    random_items(25);
    start_phase(0, 1'b1);
    random_items(15);

    // Largest field value clamps to the full pool.
    start_phase(2047, 1'b1);
    random_items(40);
    start_phase(48, 1'b1);
    random_items(40);

    // Shrink the pool under a live layout so walks and merges hit the end.
    start_phase(1024, 1'b1);
    repeat (12) send_item(OP_ALLOC, pick_request(), $urandom_range(0, 8191));
    start_phase(160, 1'b0);
    random_items(30);

    start_phase(1024, 1'b1);
    random_items(40);
    start_phase($urandom_range(3, 300), 1'b1);
    random_items(40);
    start_phase(200, 1'b1);
    random_items(40);

    wait_idle();
    repeat (200) @(negedge clk);

    $display("Covered %0d pool settings: %0d init, %0d allocate (%0d without room), %0d free, %0d query.",
             settings_run, op_count[OP_INIT], op_count[OP_ALLOC], failed_allocs,
             op_count[OP_FREE], op_count[OP_QUERY]);
    $display("%0d result beats checked, %0d mismatched.", results_seen, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
